// ===== rtl/assert_macros.svh =====
// Assertion macros used by the UART receive ring buffer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define URXRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("urxrb assertion failed");
// Checked on every clock edge, reset included.
`define URXRB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("urxrb reset assertion failed");
`else
`define URXRB_ASSERT(lbl, prop)
`define URXRB_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/urxrb_pkg.sv =====
// Package: types, codes and defaults of the UART receive ring buffer.
`timescale 1ns / 1ps
package urxrb_pkg;

  // Parameter defaults
  localparam int DefDepthLog2 = 10;
  localparam int DefMaxBurst  = 64;

  // Fixed field widths
  localparam int CntW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // Operation codes
  localparam logic [1:0] OpRx    = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRxEnabled = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRingLog2  = 2'd1;
  localparam logic [CfgDataW-1:0] RingLog2Reset = 4'd10;

  // Latched error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrFrame   = 2'd1;
  localparam logic [1:0] ErrOverrun = 2'd2;
  localparam logic [1:0] ErrParity  = 2'd3;

  // Result status codes
  localparam logic [2:0] StatOverflow = 3'd4;
  localparam logic [2:0] StatUninit   = 3'd5;

  // Configuration seen by the controller
  typedef struct packed {
    logic            enabled;
    logic            clear;
    logic [CntW-1:0] ring_len;
  } cfg_t;

endpackage

// ===== rtl/urxrb_ring_mem.sv =====
// Ring storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module urxrb_ring_mem #(
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**AddrW];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/urxrb_ctrl.sv =====
// Controller: ring counters, error latch, read bursts and the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module urxrb_ctrl import urxrb_pkg::*; #(
  parameter int DepthLog2 = DefDepthLog2,
  parameter int MaxBurst  = DefMaxBurst
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_error_i,
  input  logic                 overrun_error_i,
  input  logic                 parity_error_i,
  input  logic [6:0]           max_bytes_i,
  output logic                 mem_we_o,
  output logic [DepthLog2-1:0] mem_waddr_o,
  output logic [7:0]           mem_wdata_o,
  output logic                 mem_re_o,
  output logic [DepthLog2-1:0] mem_raddr_o,
  input  logic [7:0]           mem_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 data_valid_o,
  output logic                 last_o,
  output logic [2:0]           status_o,
  output logic [CntW-1:0]      available_o
);

  localparam int BurstW = $clog2(MaxBurst + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSingle = 2'd1;
  localparam logic [1:0] StBurst  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   wr_cnt_q, wr_cnt_d;
  logic [CntW-1:0]   rd_cnt_q, rd_cnt_d;
  logic [1:0]        err_q, err_d;
  logic [2:0]        stat_q, stat_d;
  logic [CntW-1:0]   avail_q, avail_d;
  logic [BurstW-1:0] left_q, left_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_dv_q, out_dv_d;
  logic              out_last_q, out_last_d;
  logic [2:0]        out_stat_q, out_stat_d;
  logic [CntW-1:0]   out_avail_q, out_avail_d;

  logic              in_xfer, out_free;
  logic [CntW-1:0]   mask, occupancy;
  logic [6:0]        cap;
  logic [BurstW-1:0] burst_n;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // occupancy and burst length of a read request
  assign mask      = cfg_i.ring_len - CntW'(1);
  assign occupancy = wr_cnt_q - rd_cnt_q;
  assign cap       = (max_bytes_i > 7'(MaxBurst)) ? 7'(MaxBurst) : max_bytes_i;
  assign burst_n   = (occupancy < CntW'(cap)) ? BurstW'(occupancy) : BurstW'(cap);

  // memory ports
  assign mem_waddr_o = wr_cnt_q[DepthLog2-1:0] & mask[DepthLog2-1:0];
  assign mem_raddr_o = rd_cnt_q[DepthLog2-1:0] & mask[DepthLog2-1:0];
  assign mem_wdata_o = rx_byte_i;

  // next state
  always_comb begin
    state_d     = state_q;
    wr_cnt_d    = wr_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    err_d       = err_q;
    stat_d      = stat_q;
    avail_d     = avail_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_dv_d    = out_dv_q;
    out_last_d  = out_last_q;
    out_stat_d  = out_stat_q;
    out_avail_d = out_avail_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          unique case (operation_i)
            OpRx: begin
              if (cfg_i.enabled) begin
                mem_we_o = 1'b1;
                wr_cnt_d = wr_cnt_q + CntW'(1);
                if (frame_error_i) begin
                  err_d = ErrFrame;
                end else if (overrun_error_i) begin
                  err_d = ErrOverrun;
                end else if (parity_error_i) begin
                  err_d = ErrParity;
                end else begin
                  err_d = ErrNone;
                end
              end
            end
            OpRead: begin
              if (!cfg_i.enabled) begin
                stat_d  = StatUninit;
                avail_d = '0;
                state_d = StSingle;
              end else if (occupancy > cfg_i.ring_len) begin
                wr_cnt_d = '0;
                rd_cnt_d = '0;
                err_d    = ErrNone;
                stat_d   = StatOverflow;
                avail_d  = occupancy;
                state_d  = StSingle;
              end else begin
                err_d   = ErrNone;
                stat_d  = {1'b0, err_q};
                avail_d = occupancy;
                if (burst_n == '0) begin
                  state_d = StSingle;
                end else begin
                  // first byte read issued along with the transfer
                  mem_re_o = 1'b1;
                  rd_cnt_d = rd_cnt_q + CntW'(1);
                  left_d   = burst_n;
                  state_d  = StBurst;
                end
              end
            end
            OpFlush: begin
              rd_cnt_d = wr_cnt_q;
            end
            default: begin
            end
          endcase
        end
      end
      StSingle: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_dv_d    = 1'b0;
          out_last_d  = 1'b1;
          out_stat_d  = stat_q;
          out_avail_d = avail_q;
          state_d     = StIdle;
        end
      end
      StBurst: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = mem_rdata_i;
          out_dv_d    = 1'b1;
          out_last_d  = (left_q == BurstW'(1));
          out_stat_d  = stat_q;
          out_avail_d = avail_q;
          left_d      = left_q - BurstW'(1);
          if (left_q == BurstW'(1)) begin
            state_d = StIdle;
          end else begin
            mem_re_o = 1'b1;
            rd_cnt_d = rd_cnt_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // register write resets the ring
    if (cfg_i.clear) begin
      wr_cnt_d = '0;
      rd_cnt_d = '0;
      err_d    = ErrNone;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      err_q       <= ErrNone;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_cnt_q    <= wr_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      err_q       <= err_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stat_q      <= stat_d;
    avail_q     <= avail_d;
    out_data_q  <= out_data_d;
    out_dv_q    <= out_dv_d;
    out_last_q  <= out_last_d;
    out_stat_q  <= out_stat_d;
    out_avail_q <= out_avail_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_data_q;
  assign data_valid_o = out_dv_q;
  assign last_o       = out_last_q;
  assign status_o     = out_stat_q;
  assign available_o  = out_avail_q;

  // checks
  `URXRB_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == StIdle)
  `URXRB_ASSERT(a_burst_left, state_q == StBurst |-> left_q != '0)
  `URXRB_ASSERT(a_burst_read,
    state_q == StBurst && $past(state_q) == StIdle |-> $past(mem_re_o))
  `URXRB_ASSERT(a_burst_end,
    state_q == StBurst && out_free && left_q == BurstW'(1)
      |=> state_q == StIdle && out_valid_q && out_last_q)
  `URXRB_ASSERT(a_data_stat,
    out_valid_q && out_dv_q |-> out_stat_q != StatOverflow && out_stat_q != StatUninit)

endmodule

// ===== rtl/uart_rx_ring_buffer_unit.sv =====
// Top level of the UART receive ring buffer: configuration registers and wiring.
`timescale 1ns / 1ps
// Stores received bytes in a power-of-two ring held in a single-port-write,
// single-port-read block RAM with registered read data. A received byte or a
// flush leaves the unit ready for the next request. A read request returns
// n bytes (one RAM read per byte, the first issued with the request), or a
// single result without data; the output register stalls the burst while
// the consumer holds off. Writes to either configuration register are
// registered and clear both counters and the latched error. The ring needs
// no clearing pass after reset.
module uart_rx_ring_buffer_unit import urxrb_pkg::*; #(
  parameter int DEPTH_LOG2 = DefDepthLog2,
  parameter int MAX_BURST  = DefMaxBurst
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_error_i,
  input  logic                overrun_error_i,
  input  logic                parity_error_i,
  input  logic [6:0]          max_bytes_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic                data_valid_o,
  output logic                last_o,
  output logic [2:0]          status_o,
  output logic [CntW-1:0]     available_o
);

  logic                rx_enabled_q;
  logic [CfgDataW-1:0] ring_log2_q;
  logic [CfgDataW-1:0] ring_log2_eff;
  logic                cfg_xfer;
  cfg_t                cfg;

  logic                  mem_we, mem_re;
  logic [DEPTH_LOG2-1:0] mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enabled_q <= 1'b0;
      ring_log2_q  <= RingLog2Reset;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CfgRxEnabled: rx_enabled_q <= cfg_data_i[0];
        CfgRingLog2:  ring_log2_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ring length in use, limited to the storage
  assign ring_log2_eff = (ring_log2_q > CfgDataW'(DEPTH_LOG2)) ?
                         CfgDataW'(DEPTH_LOG2) : ring_log2_q;
  assign cfg.enabled   = rx_enabled_q;
  assign cfg.clear     = cfg_xfer &&
                         (cfg_index_i == CfgRxEnabled || cfg_index_i == CfgRingLog2);
  assign cfg.ring_len  = CntW'(1) << ring_log2_eff;

  urxrb_ctrl #(
    .DepthLog2(DEPTH_LOG2),
    .MaxBurst (MAX_BURST)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .rx_byte_i,
    .frame_error_i,
    .overrun_error_i,
    .parity_error_i,
    .max_bytes_i,
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o,
    .out_ready_i,
    .data_byte_o,
    .data_valid_o,
    .last_o,
    .status_o,
    .available_o
  );

  urxrb_ring_mem #(
    .AddrW(DEPTH_LOG2)
  ) u_ring_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
